@@ rtl/skt_pkg.sv @@
// Shared types and constants for the sorted key table.
`timescale 1ns / 1ps
`default_nettype none

package skt_pkg;

    localparam int CAPACITY = 256;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KEY_W    = 32;
    localparam int PAGE_W   = 32;
    localparam int SLOT_W   = 16;
    localparam int STAT_W   = 3;
    localparam int ECNT_W   = 9;

    typedef enum logic {
        CMD_INSERT = 1'b0,
        CMD_SEARCH = 1'b1
    } t_cmd;

    typedef enum logic [STAT_W-1:0] {
        STAT_INSERTED  = 3'd0,
        STAT_DUPLICATE = 3'd1,
        STAT_FULL      = 3'd2,
        STAT_FOUND     = 3'd3,
        STAT_NOT_FOUND = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_COMPARE,
        ST_SCAN,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } t_entry;

    // Match token walking down the cell row.
    typedef struct packed {
        logic              hit;
        logic [PAGE_W-1:0] page;
        logic [SLOT_W-1:0] slot;
    } t_token;

    // Broadcast from the controller to every cell.
    typedef struct packed {
        logic   compare;
        logic   commit;
        t_entry req;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ rtl/sorted_key_table_core.sv @@
// Top level of the sorted key table: sequencer plus a row of compare-and-shift cells.
`timescale 1ns / 1ps
`default_nettype none
// Sequence: the request is accepted in idle, the compare state registers each cell's
//   compare result, the match token walks the cell row in the scan state, and the
//   finish state registers the result once the output side is free; input stalls till idle.
// The result register frees the input side: a new request is taken while a result waits.
// Reset (synchronous, active low) clears the sequencer, entry count and result valid;
//   cell contents are not cleared, only entries below the count are ever used.

module sorted_key_table_core (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request channel
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic signed [skt_pkg::KEY_W-1:0]  i_key,
    input  logic signed [skt_pkg::PAGE_W-1:0] i_rid_page,
    input  logic [skt_pkg::SLOT_W-1:0]        i_rid_slot,
    // result channel
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [skt_pkg::STAT_W-1:0]        o_status,
    output logic signed [skt_pkg::PAGE_W-1:0] o_found_page,
    output logic [skt_pkg::SLOT_W-1:0]        o_found_slot,
    output logic [skt_pkg::ECNT_W-1:0]        o_entry_count
);
    import skt_pkg::*;

    t_cell_ctl        w_ctl;
    logic [CNT_W-1:0] w_count;

    // Neighbor links: element g feeds cell g, element g+1 comes out of it.
    logic             w_lt    [CAPACITY+1];
    t_entry           w_entry [CAPACITY+1];
    t_token           w_tok   [CAPACITY+1];
    logic             w_occ   [CAPACITY];

    // Left edge: everything "before" cell 0 counts as smaller, no match yet.
    assign w_lt[0]    = 1'b1;
    assign w_entry[0] = w_ctl.req;
    assign w_tok[0]   = '0;

    skt_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_rid_page    (i_rid_page),
        .i_rid_slot    (i_rid_slot),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_status      (o_status),
        .o_found_page  (o_found_page),
        .o_found_slot  (o_found_slot),
        .o_entry_count (o_entry_count),
        .i_last_tok    (w_tok[CAPACITY]),
        .o_ctl         (w_ctl),
        .o_count       (w_count)
    );

    // Occupied cells form a prefix of the row; each compare result is gated by it,
    // so the "less than" flags form a prefix as well and mark the insert point.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        assign w_occ[g] = (CNT_W'(g) < w_count);

        skt_cell u_cell (
            .i_clk        (i_clk),
            .i_ctl        (w_ctl),
            .i_occupied   (w_occ[g]),
            .i_prev_lt    (w_lt[g]),
            .i_prev_entry (w_entry[g]),
            .i_tok        (w_tok[g]),
            .o_lt         (w_lt[g+1]),
            .o_entry      (w_entry[g+1]),
            .o_tok        (w_tok[g+1])
        );
    end

endmodule

`default_nettype wire

@@ rtl/skt_cell.sv @@
// One table cell: holds an entry, compares it, shifts on insert, passes the match token.
`timescale 1ns / 1ps
`default_nettype none

module skt_cell (
    input  logic               i_clk,
    input  skt_pkg::t_cell_ctl i_ctl,
    input  logic               i_occupied,
    input  logic               i_prev_lt,
    input  skt_pkg::t_entry    i_prev_entry,
    input  skt_pkg::t_token    i_tok,
    output logic               o_lt,
    output skt_pkg::t_entry    o_entry,
    output skt_pkg::t_token    o_tok
);
    import skt_pkg::*;

    t_entry r_entry;
    t_entry n_entry;
    t_token r_tok;
    t_token n_tok;
    logic   r_lt;
    logic   r_eq;

    // Insert: smaller entries stay, the boundary cell takes the new entry,
    // everything above moves up one place.
    always_comb begin
        if (r_lt) begin
            n_entry = r_entry;
        end else if (i_prev_lt) begin
            n_entry = i_ctl.req;
        end else begin
            n_entry = i_prev_entry;
        end
    end

    always_comb begin
        if (r_eq && !i_tok.hit) begin
            n_tok.hit  = 1'b1;
            n_tok.page = r_entry.page;
            n_tok.slot = r_entry.slot;
        end else begin
            n_tok = i_tok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.compare) begin
            r_lt <= i_occupied && ($signed(r_entry.key) < $signed(i_ctl.req.key));
            r_eq <= i_occupied && (r_entry.key == i_ctl.req.key);
        end
        if (i_ctl.commit) begin
            r_entry <= n_entry;
        end
        r_tok <= n_tok;
    end

    assign o_lt    = r_lt;
    assign o_entry = r_entry;
    assign o_tok   = r_tok;

endmodule

`default_nettype wire

@@ rtl/skt_ctrl.sv @@
// Request sequencer: captures a request, runs compare and scan, commits, registers the result.
`timescale 1ns / 1ps
`default_nettype none

module skt_ctrl (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic                              i_command,
    input  logic signed [skt_pkg::KEY_W-1:0]  i_key,
    input  logic signed [skt_pkg::PAGE_W-1:0] i_rid_page,
    input  logic [skt_pkg::SLOT_W-1:0]        i_rid_slot,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic [skt_pkg::STAT_W-1:0]        o_status,
    output logic signed [skt_pkg::PAGE_W-1:0] o_found_page,
    output logic [skt_pkg::SLOT_W-1:0]        o_found_slot,
    output logic [skt_pkg::ECNT_W-1:0]        o_entry_count,
    input  skt_pkg::t_token                   i_last_tok,
    output skt_pkg::t_cell_ctl                o_ctl,
    output logic [skt_pkg::CNT_W-1:0]         o_count
);
    import skt_pkg::*;

    localparam logic [CNT_W-1:0] SCAN_LAST = CNT_W'(CAPACITY - 1);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(CAPACITY);

    t_state            r_state;
    t_state            n_state;
    t_cmd              r_cmd;
    t_entry            r_req;
    logic [CNT_W-1:0]  r_scan;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  n_count;

    logic              r_out_valid;
    t_status           r_status;
    t_status           n_status;
    logic [PAGE_W-1:0] r_fpage;
    logic [SLOT_W-1:0] r_fslot;
    logic [ECNT_W-1:0] r_ecnt;

    logic              w_accept;
    logic              w_can_write;
    logic              w_finish;
    logic              w_insert_ok;

    assign w_can_write = !r_out_valid || !i_out_stall;
    assign w_insert_ok = (r_cmd == CMD_INSERT) && !i_last_tok.hit && (r_count != CNT_FULL);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) n_state = ST_COMPARE;
            end
            ST_COMPARE: n_state = ST_SCAN;
            ST_SCAN: begin
                if (r_scan == SCAN_LAST) n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (w_can_write) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb begin
        o_in_stall = 1'b1;
        w_accept   = 1'b0;
        w_finish   = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall = 1'b0;
                w_accept   = i_in_valid;
            end
            ST_COMPARE: ;
            ST_SCAN: ;
            ST_FINISH: begin
                w_finish = w_can_write;
            end
            default: ;
        endcase
    end

    always_comb begin
        o_ctl.compare = (r_state == ST_COMPARE);
        o_ctl.commit  = w_finish && w_insert_ok;
        o_ctl.req     = r_req;
    end

    always_comb begin
        if (r_cmd == CMD_INSERT) begin
            if (i_last_tok.hit) begin
                n_status = STAT_DUPLICATE;
            end else if (r_count == CNT_FULL) begin
                n_status = STAT_FULL;
            end else begin
                n_status = STAT_INSERTED;
            end
        end else begin
            n_status = i_last_tok.hit ? STAT_FOUND : STAT_NOT_FOUND;
        end
        n_count = w_insert_ok ? r_count + 1'b1 : r_count;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_finish) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd      <= t_cmd'(i_command);
            r_req.key  <= i_key;
            r_req.page <= i_rid_page;
            r_req.slot <= i_rid_slot;
        end
        if (r_state == ST_COMPARE) begin
            r_scan <= '0;
        end else if (r_state == ST_SCAN) begin
            r_scan <= r_scan + 1'b1;
        end
        if (w_finish) begin
            r_status <= n_status;
            r_ecnt   <= ECNT_W'(n_count);
            if (n_status == STAT_FOUND) begin
                r_fpage <= i_last_tok.page;
                r_fslot <= i_last_tok.slot;
            end else begin
                r_fpage <= '0;
                r_fslot <= '0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_page  = $signed(r_fpage);
    assign o_found_slot  = r_fslot;
    assign o_entry_count = r_ecnt;
    assign o_count       = r_count;

endmodule

`default_nettype wire
